>>> sv/srsh_pkg.sv
// srsh_pkg: shared constants, codes and control types for the signed region size histogram
// used by srsh_size, srsh_rmw and the top module; depends on nothing
`default_nettype none

package srsh_pkg;

   // default histogram geometry
   localparam int MAX_SIZE_DEF = 1023;
   localparam int DEL_BINS_DEF = 1024;

   // fixed field widths
   localparam int VT_W    = 3;
   localparam int POS_W   = 31;
   localparam int SLEN_W  = 32;
   localparam int IDX_W   = 12;
   localparam int CNT_W   = 32;
   localparam int DIFF_W  = POS_W + 2;
   localparam int SIZE_W  = DIFF_W + 1;
   localparam int REQ_W   = 176;
   localparam int RSP_W   = 48;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // item kinds
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // variant type codes
   localparam logic [VT_W-1:0] VT_DEL    = 3'd0;
   localparam logic [VT_W-1:0] VT_TRA    = 3'd1;
   localparam logic [VT_W-1:0] VT_BND    = 3'd2;
   localparam logic [VT_W-1:0] VT_INVTRA = 3'd3;

   // lookup request from the size pipeline to the counter stage
   typedef struct packed {
      logic vld;
      logic is_read;
      logic ok;
   } srsh_ctl_type;

   // status and read result from the counter stage
   typedef struct packed {
      logic             clearing;
      logic             rd_vld;
      logic [IDX_W-1:0] index;
      logic [CNT_W-1:0] count;
   } srsh_out_type;

endpackage

`default_nettype wire

>>> sv/srsh_ram.sv
// srsh_ram: generic single-write, single-read ram with registered read data
// standalone; no package needed
`default_nettype none

module srsh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2050
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/srsh_size.sv
// srsh_size: four-stage pipeline that turns an item into a bin address
// depends on srsh_pkg
`default_nettype none

module srsh_size #(
   parameter int MAX_SIZE = srsh_pkg::MAX_SIZE_DEF,
   parameter int DEL_BINS = srsh_pkg::DEL_BINS_DEF,
   localparam int NBINS   = DEL_BINS + MAX_SIZE + 3,
   localparam int AW      = $clog2(NBINS)
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             advance,
   input  wire                             in_vld,
   input  wire                             in_kind,
   input  wire  [srsh_pkg::VT_W-1:0]       in_vtype,
   input  wire                             in_prim,
   input  wire  [srsh_pkg::POS_W-1:0]      in_s0,
   input  wire  [srsh_pkg::POS_W-1:0]      in_e0,
   input  wire  [srsh_pkg::POS_W-1:0]      in_s1,
   input  wire  [srsh_pkg::POS_W-1:0]      in_e1,
   input  wire  [srsh_pkg::SLEN_W-1:0]     in_slen,
   input  wire  [srsh_pkg::IDX_W-1:0]      in_rbin,
   output srsh_pkg::srsh_ctl_type          lk_ctl,
   output logic [AW-1:0]                   lk_addr,
   output logic [srsh_pkg::IDX_W-1:0]      lk_rbin
);

   localparam int DW = srsh_pkg::DIFF_W;
   localparam int SW = srsh_pkg::SIZE_W;
   localparam logic signed [SW-1:0] SIZE_LO = SW'(-DEL_BINS);
   localparam logic signed [SW-1:0] SIZE_HI = SW'(MAX_SIZE);
   localparam logic signed [SW-1:0] SIZE_OFS = SW'(DEL_BINS + 1);
   localparam logic [AW-1:0] BIN_LAST = AW'(NBINS - 1);
   localparam logic [31:0] NBINS_32 = 32'(NBINS);

   // stage 1: coordinate difference
   logic                          v1_ff, read1_ff, del1_ff;
   logic signed [DW-1:0]          diff1_ff;
   logic signed [DW-1:0]          diff1_in;
   logic [srsh_pkg::SLEN_W-1:0]   slen1_ff;
   logic [srsh_pkg::IDX_W-1:0]    rbin1_ff;
   logic                          skip1_in;

   // stage 2: raised size
   logic                          v2_ff, read2_ff, del2_ff;
   logic signed [DW-1:0]          size2_ff;
   logic signed [DW-1:0]          slen_ext;
   logic [srsh_pkg::IDX_W-1:0]    rbin2_ff;

   // stage 3: signed size
   logic                          v3_ff, read3_ff;
   logic signed [SW-1:0]          size3_ff;
   logic [srsh_pkg::IDX_W-1:0]    rbin3_ff;

   // stage 4: bin address
   srsh_pkg::srsh_ctl_type        ctl4_ff;
   logic [AW-1:0]                 addr4_ff;
   logic [srsh_pkg::IDX_W-1:0]    rbin4_ff;
   logic signed [SW-1:0]          bin_sum;
   logic [AW-1:0]                 rec_addr;
   logic                          rd_range;

   // type filter and selected difference
   always_comb begin
      skip1_in = (in_kind == srsh_pkg::KIND_RECORD) &&
                 (in_vtype inside {srsh_pkg::VT_TRA, srsh_pkg::VT_BND, srsh_pkg::VT_INVTRA});
      if (in_prim) begin
         diff1_in = $signed({2'b00, in_e0}) - $signed({2'b00, in_s0});
      end else begin
         diff1_in = $signed({2'b00, in_e1}) - $signed({2'b00, in_s1});
      end
   end

   assign slen_ext = $signed({slen1_ff[srsh_pkg::SLEN_W-1], slen1_ff});

   // clamp into the bin range
   always_comb begin
      bin_sum  = size3_ff + SIZE_OFS;
      rd_range = {20'd0, rbin3_ff} < NBINS_32;
      if (size3_ff < SIZE_LO) begin
         rec_addr = '0;
      end else if (size3_ff > SIZE_HI) begin
         rec_addr = BIN_LAST;
      end else begin
         rec_addr = bin_sum[AW-1:0];
      end
   end

   // valid bits and payload stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         ctl4_ff.vld <= 1'b0;
      end else if (advance) begin
         v1_ff       <= in_vld && !skip1_in;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         ctl4_ff.vld <= v3_ff;
      end
      if (advance) begin
         read1_ff <= (in_kind == srsh_pkg::KIND_READ);
         del1_ff  <= (in_vtype == srsh_pkg::VT_DEL);
         diff1_ff <= diff1_in;
         slen1_ff <= in_slen;
         rbin1_ff <= in_rbin;

         read2_ff <= read1_ff;
         del2_ff  <= del1_ff;
         size2_ff <= (diff1_ff < slen_ext) ? slen_ext : diff1_ff;
         rbin2_ff <= rbin1_ff;

         read3_ff <= read2_ff;
         size3_ff <= del2_ff ? -$signed({size2_ff[DW-1], size2_ff})
                             : $signed({size2_ff[DW-1], size2_ff});
         rbin3_ff <= rbin2_ff;

         ctl4_ff.is_read <= read3_ff;
         ctl4_ff.ok      <= read3_ff ? rd_range : 1'b1;
         addr4_ff        <= read3_ff ? AW'(rbin3_ff) : rec_addr;
         rbin4_ff        <= rbin3_ff;
      end
   end

   assign lk_ctl  = ctl4_ff;
   assign lk_addr = addr4_ff;
   assign lk_rbin = rbin4_ff;

endmodule

`default_nettype wire

>>> sv/srsh_rmw.sv
// srsh_rmw: counter store with read-modify-write, forwarding and the clearing pass
// depends on srsh_pkg and srsh_ram
`default_nettype none

module srsh_rmw #(
   parameter int MAX_SIZE = srsh_pkg::MAX_SIZE_DEF,
   parameter int DEL_BINS = srsh_pkg::DEL_BINS_DEF,
   localparam int NBINS   = DEL_BINS + MAX_SIZE + 3,
   localparam int AW      = $clog2(NBINS)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         advance,
   input  wire srsh_pkg::srsh_ctl_type lk_ctl,
   input  wire  [AW-1:0]               lk_addr,
   input  wire  [srsh_pkg::IDX_W-1:0]  lk_rbin,
   output srsh_pkg::srsh_out_type      st_out
);

   localparam int CW = srsh_pkg::CNT_W;
   localparam logic [AW-1:0] BIN_LAST = AW'(NBINS - 1);

   // counter stage registers
   srsh_pkg::srsh_ctl_type        f_ctl_ff;
   logic [AW-1:0]                 f_addr_ff;
   logic [srsh_pkg::IDX_W-1:0]    f_rbin_ff;

   // forwarding of the last write
   logic                          fwd_hit_ff;
   logic [CW-1:0]                 fwd_data_ff;

   // clearing pass
   logic                          clr_busy_ff;
   logic [AW-1:0]                 clr_addr_ff;

   logic [CW-1:0]                 ram_rd;
   logic [CW-1:0]                 cur_cnt;
   logic [CW-1:0]                 new_cnt;
   logic                          rec_wr;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [CW-1:0]                 wr_data;

   // current count and saturating increment
   always_comb begin
      cur_cnt = fwd_hit_ff ? fwd_data_ff : ram_rd;
      new_cnt = (cur_cnt == srsh_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
      rec_wr  = f_ctl_ff.vld && !f_ctl_ff.is_read && f_ctl_ff.ok && advance;
      wr_en   = clr_busy_ff || rec_wr;
      wr_addr = clr_busy_ff ? clr_addr_ff : f_addr_ff;
      wr_data = clr_busy_ff ? '0 : new_cnt;
   end

   srsh_ram #(
      .WIDTH (CW),
      .DEPTH (NBINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (lk_addr),
      .rd_data (ram_rd)
   );

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == BIN_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // stage valid, forward hit and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         f_ctl_ff.vld <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else if (advance) begin
         f_ctl_ff.vld <= lk_ctl.vld;
         fwd_hit_ff   <= rec_wr && lk_ctl.vld && (lk_addr == f_addr_ff);
      end
      if (advance) begin
         f_ctl_ff.is_read <= lk_ctl.is_read;
         f_ctl_ff.ok      <= lk_ctl.ok;
         f_addr_ff        <= lk_addr;
         f_rbin_ff        <= lk_rbin;
         fwd_data_ff      <= new_cnt;
      end
   end

   assign st_out = '{clearing: clr_busy_ff,
                     rd_vld:   f_ctl_ff.vld && f_ctl_ff.is_read,
                     index:    f_rbin_ff,
                     count:    f_ctl_ff.ok ? cur_cnt : '0};

endmodule

`default_nettype wire

>>> sv/signed_region_size_histogram.sv
// Histogram of signed variant region sizes, built on a single counter ram with
// read-modify-write. After reset the block clears all DEL_BINS + MAX_SIZE + 3
// counters in the ram (2050 with the default sizes), with req_tready low.
// From then on it takes one beat per cycle while the pipeline is not held. A
// record beat passes the size stages and the counter stage into its bin, a read
// beat the same path into the rsp output register. The rate is set by the ram's
// one write and one read port; a record that hits the same bin as the record
// just ahead of it gets the fresh count through a forwarding register, so no
// bubbles are needed. The pipeline holds only while a read result reaches the
// output register and the one there has not been taken yet.
// depends on srsh_pkg, srsh_size, srsh_rmw and srsh_ram
`default_nettype none

module signed_region_size_histogram #(
   parameter int MAX_SIZE = srsh_pkg::MAX_SIZE_DEF,
   parameter int DEL_BINS = srsh_pkg::DEL_BINS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // request side
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // var_type[2:0], has_primary_chrom[3], start_pos[34:4], end_pos[65:35],
   // start_pos_alt[96:66], end_pos_alt[127:97], stated_length[159:128],
   // read_bin[171:160], zero fill above
   input  wire  [srsh_pkg::REQ_W-1:0]   req_tdata,
   // kind[0]
   input  wire                          req_tuser,
   // response side
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // bin_index[11:0], bin_count[43:12], zero fill above
   output logic [srsh_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int NBINS = DEL_BINS + MAX_SIZE + 3;
   localparam int AW    = $clog2(NBINS);
   localparam logic [31:0] NBINS_32 = 32'(NBINS);

   srsh_pkg::srsh_ctl_type        lk_ctl;
   logic [AW-1:0]                 lk_addr;
   logic [srsh_pkg::IDX_W-1:0]    lk_rbin;
   srsh_pkg::srsh_out_type        st_out;

   logic                          advance;
   logic                          in_vld;
   logic                          rsp_tvalid_ff;
   logic [srsh_pkg::IDX_W-1:0]    rsp_index_ff;
   logic [srsh_pkg::CNT_W-1:0]    rsp_count_ff;

   // hold the pipe only when a read result cannot be placed
   assign advance    = !(st_out.rd_vld && rsp_tvalid_ff && !rsp_tready);
   assign req_tready = advance && !st_out.clearing;
   assign in_vld     = req_tvalid && req_tready;

   srsh_size #(
      .MAX_SIZE (MAX_SIZE),
      .DEL_BINS (DEL_BINS)
   ) u_size (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_vld   (in_vld),
      .in_kind  (req_tuser),
      .in_vtype (req_tdata[2:0]),
      .in_prim  (req_tdata[3]),
      .in_s0    (req_tdata[34:4]),
      .in_e0    (req_tdata[65:35]),
      .in_s1    (req_tdata[96:66]),
      .in_e1    (req_tdata[127:97]),
      .in_slen  (req_tdata[159:128]),
      .in_rbin  (req_tdata[171:160]),
      .lk_ctl   (lk_ctl),
      .lk_addr  (lk_addr),
      .lk_rbin  (lk_rbin)
   );

   srsh_rmw #(
      .MAX_SIZE (MAX_SIZE),
      .DEL_BINS (DEL_BINS)
   ) u_rmw (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .lk_ctl   (lk_ctl),
      .lk_addr  (lk_addr),
      .lk_rbin  (lk_rbin),
      .st_out   (st_out)
   );

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance && st_out.rd_vld) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && st_out.rd_vld) begin
         rsp_index_ff <= st_out.index;
         rsp_count_ff <= st_out.count;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_count_ff, rsp_index_ff};

   // no beat is taken while the counters are being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      st_out.clearing |-> !req_tready)
      else $error("request beat accepted during clearing pass");

   // the clearing pass follows every reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> st_out.clearing && !req_tready)
      else $error("clearing pass not started after reset");

   // a bin beyond the store always reads as zero
   a_oob_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ({20'd0, rsp_tdata[11:0]} >= NBINS_32) |-> rsp_tdata[43:12] == '0)
      else $error("out of range bin returned a nonzero count");

   // the pipe only stalls on a waiting read result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !advance |-> rsp_tvalid && !rsp_tready && st_out.rd_vld)
      else $error("pipeline stalled without a blocked read result");

endmodule

`default_nettype wire

>>> sim/srsh_tb_pkg.sv
// srsh_tb_pkg: beat layouts and bin geometry shared by the histogram testbench files
// depends on srsh_pkg
`default_nettype none

package srsh_tb_pkg;

   localparam int NBINS    = srsh_pkg::DEL_BINS_DEF + srsh_pkg::MAX_SIZE_DEF + 3;
   // bin that holds size 0
   localparam int ZERO_BIN = srsh_pkg::DEL_BINS_DEF + 1;
   localparam int IDX_TOP  = (1 << srsh_pkg::IDX_W) - 1;

   // request tdata, lowest field at the bottom
   typedef struct packed {
      logic [3:0]                          pad;
      logic [srsh_pkg::IDX_W-1:0]          read_bin;
      logic signed [srsh_pkg::SLEN_W-1:0]  stated_length;
      logic [srsh_pkg::POS_W-1:0]          end_pos_alt;
      logic [srsh_pkg::POS_W-1:0]          start_pos_alt;
      logic [srsh_pkg::POS_W-1:0]          end_pos;
      logic [srsh_pkg::POS_W-1:0]          start_pos;
      logic                                has_primary_chrom;
      logic [srsh_pkg::VT_W-1:0]           var_type;
   } region_beat_type;

   // response tdata
   typedef struct packed {
      logic [3:0]                 pad;
      logic [srsh_pkg::CNT_W-1:0] bin_count;
      logic [srsh_pkg::IDX_W-1:0] bin_index;
   } bin_beat_type;

   // one expected bin read
   typedef struct {
      logic [srsh_pkg::IDX_W-1:0] index;
      logic [srsh_pkg::CNT_W-1:0] count;
   } bin_read_type;

endpackage

`default_nettype wire

>>> sim/srsh_bin_checker.sv
// srsh_bin_checker: watches both streams, keeps its own copy of the bin counters
// and compares every bin read against it; depends on srsh_pkg and srsh_tb_pkg
`default_nettype none

module srsh_bin_checker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   input  wire                         req_tready,
   input  wire  [srsh_pkg::REQ_W-1:0]  req_tdata,
   input  wire                         req_tuser,
   input  wire                         rsp_tvalid,
   input  wire                         rsp_tready,
   input  wire  [srsh_pkg::RSP_W-1:0]  rsp_tdata,
   output int                          mismatches,
   output int                          reads_pending
);

   localparam int NBINS    = srsh_tb_pkg::NBINS;
   localparam int ZERO_BIN = srsh_tb_pkg::ZERO_BIN;

   logic [srsh_pkg::CNT_W-1:0]    bin_tally [NBINS];
   srsh_tb_pkg::bin_read_type     expected_reads [$];
   int                            err_count = 0;
   srsh_tb_pkg::region_beat_type  in_beat;
   srsh_tb_pkg::bin_beat_type     out_beat;
   srsh_tb_pkg::bin_read_type     want;
   int                            hit;

   assign mismatches = err_count;

   // bin a record lands in, or -1 for the skipped types
   function automatic int region_bin(srsh_tb_pkg::region_beat_type b);
      longint size_v;
      longint floor_v;
      if (b.var_type == srsh_pkg::VT_TRA || b.var_type == srsh_pkg::VT_BND ||
          b.var_type == srsh_pkg::VT_INVTRA)
         return -1;
      // coordinates are unsigned, stated length is signed: 64 bits never wrap
      if (b.has_primary_chrom)
         size_v = longint'(b.end_pos) - longint'(b.start_pos);
      else
         size_v = longint'(b.end_pos_alt) - longint'(b.start_pos_alt);
      floor_v = longint'(b.stated_length);
      if (size_v < floor_v)
         size_v = floor_v;
      if (b.var_type == srsh_pkg::VT_DEL)
         size_v = -size_v;
      if (size_v < -longint'(srsh_pkg::DEL_BINS_DEF))
         return 0;
      if (size_v > longint'(srsh_pkg::MAX_SIZE_DEF))
         return NBINS - 1;
      return int'(size_v) + ZERO_BIN;
   endfunction

   function automatic void log_mismatch(string msg);
      if (err_count < 10)
         $display("%s", msg);
      err_count++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (bin_tally[i])
            bin_tally[i] = '0;
         expected_reads.delete();
      end else begin
         // results first, a read taken this edge cannot be answered yet
         if (rsp_tvalid && rsp_tready) begin
            out_beat = rsp_tdata;
            if (expected_reads.size() == 0) begin
               log_mismatch($sformatf("unexpected bin read: index %0d count %0d",
                  out_beat.bin_index, out_beat.bin_count));
            end else begin
               want = expected_reads.pop_front();
               if (out_beat.bin_index !== want.index || out_beat.bin_count !== want.count)
                  log_mismatch($sformatf(
                     "bin read mismatch: expected index %0d count %0d, got index %0d count %0d",
                     want.index, want.count, out_beat.bin_index, out_beat.bin_count));
            end
         end
         // requests update the counters or queue a read
         if (req_tvalid && req_tready) begin
            in_beat = req_tdata;
            if (req_tuser == srsh_pkg::KIND_RECORD) begin
               hit = region_bin(in_beat);
               if (hit >= 0 && bin_tally[hit] != srsh_pkg::CNT_MAX)
                  bin_tally[hit] = bin_tally[hit] + 1'b1;
            end else begin
               want.index = in_beat.read_bin;
               if (int'(in_beat.read_bin) < NBINS)
                  want.count = bin_tally[in_beat.read_bin];
               else
                  want.count = '0;
               expected_reads = {expected_reads, want};
            end
         end
      end
      reads_pending <= expected_reads.size();
   end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: drives records and bin reads into the size histogram in random bursts,
// stalls the result side and reports the verdict; depends on srsh_pkg, srsh_tb_pkg,
// srsh_bin_checker and signed_region_size_histogram
`default_nettype none

module tb_top;

   localparam int NBINS          = srsh_tb_pkg::NBINS;
   localparam int ZERO_BIN       = srsh_tb_pkg::ZERO_BIN;
   localparam int IDX_TOP        = srsh_tb_pkg::IDX_TOP;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_BEATS   = 825;
   localparam int HOT_SPAN       = 45;
   localparam logic [srsh_pkg::VT_W-1:0] VT_GEN_FIRST = 3'd4;
   localparam logic [srsh_pkg::VT_W-1:0] VT_GEN_LAST  = 3'd7;
   localparam logic signed [31:0] SLEN_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] SLEN_MAX = 32'sh7FFF_FFFF;
   localparam longint POS_MAX = 64'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [srsh_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [srsh_pkg::RSP_W-1:0] rsp_tdata;

   int mismatches;
   int reads_pending;
   int n_records = 0;
   int n_skipped = 0;
   int n_reads   = 0;
   int n_oob     = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   int stall_mode = 0;

   always #2 clock = ~clock;

   signed_region_size_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   srsh_bin_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatches    (mismatches),
      .reads_pending (reads_pending)
   );

   // one beat, held until taken
   task automatic send_beat(input logic kind, input srsh_tb_pkg::region_beat_type b);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      if (kind == srsh_pkg::KIND_READ) begin
         n_reads++;
         if (int'(b.read_bin) >= NBINS)
            n_oob++;
      end else begin
         n_records++;
         if (b.var_type == srsh_pkg::VT_TRA || b.var_type == srsh_pkg::VT_BND ||
             b.var_type == srsh_pkg::VT_INVTRA)
            n_skipped++;
      end
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold off until every bin read has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reads_pending != 0);
   endtask

   function automatic srsh_tb_pkg::region_beat_type record_beat(input logic [2:0] vt,
         input logic prim, input longint s, input longint e, input longint sa,
         input longint ea, input logic signed [31:0] slen);
      srsh_tb_pkg::region_beat_type b;
      b = '0;
      b.var_type          = vt;
      b.has_primary_chrom = prim;
      b.start_pos         = 31'(s);
      b.end_pos           = 31'(e);
      b.start_pos_alt     = 31'(sa);
      b.end_pos_alt       = 31'(ea);
      b.stated_length     = slen;
      return b;
   endfunction

   function automatic srsh_tb_pkg::region_beat_type read_beat(input int bin);
      srsh_tb_pkg::region_beat_type b;
      b = '0;
      b.read_bin = 12'(bin);
      return b;
   endfunction

   // random start with end = start + diff, both inside the coordinate range
   function automatic void place_size(input longint diff, output logic [30:0] s,
         output logic [30:0] e);
      longint lo;
      longint hi;
      longint s_v;
      lo  = (diff < 0) ? -diff : 0;
      hi  = POS_MAX - ((diff > 0) ? diff : 0);
      s_v = longint'($urandom_range(32'(hi), 32'(lo)));
      s   = 31'(s_v);
      e   = 31'(s_v + diff);
   endfunction

   // records mostly near size 0 so the reads find busy bins
   function automatic srsh_tb_pkg::region_beat_type random_record();
      srsh_tb_pkg::region_beat_type b;
      int t;
      longint diff;
      b.pad           = '0;
      b.read_bin      = 12'($urandom);
      b.start_pos     = 31'($urandom);
      b.end_pos       = 31'($urandom);
      b.start_pos_alt = 31'($urandom);
      b.end_pos_alt   = 31'($urandom);
      b.has_primary_chrom = 1'($urandom_range(0, 1));
      // type mix
      t = $urandom_range(0, 99);
      if (t < 35)
         b.var_type = srsh_pkg::VT_DEL;
      else if (t < 45)
         b.var_type = 3'($urandom_range(srsh_pkg::VT_TRA, srsh_pkg::VT_INVTRA));
      else
         b.var_type = 3'($urandom_range(VT_GEN_FIRST, VT_GEN_LAST));
      // size spread
      t = $urandom_range(0, 99);
      if (t < 65)
         diff = longint'($urandom_range(0, 2 * HOT_SPAN)) - HOT_SPAN;
      else if (t < 88)
         diff = longint'($urandom_range(0, 2400)) - 1200;
      else
         diff = longint'($urandom_range(0, 32'h7FFF_FFFF)) -
                longint'($urandom_range(0, 32'h7FFF_FFFF));
      if (b.has_primary_chrom)
         place_size(diff, b.start_pos, b.end_pos);
      else
         place_size(diff, b.start_pos_alt, b.end_pos_alt);
      // stated length: mostly too low to matter, sometimes raising the size
      t = $urandom_range(0, 99);
      if (t < 55)
         b.stated_length = {1'b1, 31'($urandom)};
      else if (t < 80)
         b.stated_length = 32'(longint'($urandom_range(0, 2 * HOT_SPAN)) - HOT_SPAN);
      else
         b.stated_length = $urandom;
      return b;
   endfunction

   function automatic srsh_tb_pkg::region_beat_type random_read();
      srsh_tb_pkg::region_beat_type b;
      int t;
      b.pad               = '0;
      b.var_type          = 3'($urandom);
      b.has_primary_chrom = 1'($urandom);
      b.start_pos         = 31'($urandom);
      b.end_pos           = 31'($urandom);
      b.start_pos_alt     = 31'($urandom);
      b.end_pos_alt       = 31'($urandom);
      b.stated_length     = $urandom;
      t = $urandom_range(0, 99);
      if (t < 55)
         b.read_bin = 12'(ZERO_BIN - HOT_SPAN + int'($urandom_range(0, 2 * HOT_SPAN)));
      else if (t < 80)
         b.read_bin = 12'($urandom_range(0, NBINS - 1));
      else if (t < 88)
         b.read_bin = $urandom_range(0, 1) ? 12'(NBINS - 1) : 12'd0;
      else
         b.read_bin = 12'($urandom_range(NBINS, IDX_TOP));
      return b;
   endfunction

   // result side stall patterns: open, coin flip, mostly open, mostly shut
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(4, 48);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 5) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int probe_bins [] = '{0, 1, ZERO_BIN - 7, ZERO_BIN - 1, ZERO_BIN, ZERO_BIN - 500,
                            NBINS - 2, NBINS - 1, NBINS};
      int sent;
      int burst;
      int gap;
      bit mid_drained;
      sent = 0;
      mid_drained = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty store, including a read past the last bin with every index bit set
      send_beat(srsh_pkg::KIND_READ, read_beat(0));
      send_beat(srsh_pkg::KIND_READ, read_beat(NBINS - 1));
      send_beat(srsh_pkg::KIND_READ, read_beat(IDX_TOP));
      // size 0, -1, and the deletion edges via the secondary pair
      send_beat(srsh_pkg::KIND_RECORD, record_beat(VT_GEN_FIRST, 1, 100, 100, 7, 900, SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_DEL, 1, 0, 1, 0, 0, SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_DEL, 0, 0, 500, 0, 1024,
                                                   SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_DEL, 0, 0, 500, 0, 1025,
                                                   SLEN_MIN));
      // top of the positive range and just past it
      send_beat(srsh_pkg::KIND_RECORD, record_beat(VT_GEN_LAST, 1, 0, 1023, 0, 0, SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(VT_GEN_LAST, 1, 0, 1024, 0, 0, SLEN_MIN));
      // reversed coordinates, widest difference, plain and negated
      send_beat(srsh_pkg::KIND_RECORD, record_beat(VT_GEN_FIRST, 1, POS_MAX, 0, 0, 0, SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_DEL, 1, POS_MAX, 0, 0, 0,
                                                   SLEN_MIN));
      // stated length raising the size
      send_beat(srsh_pkg::KIND_RECORD, record_beat(VT_GEN_LAST, 1, 0, 0, 0, 0, SLEN_MAX));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_DEL, 1, 5, 5, 0, 0, 500));
      // skipped types
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_TRA, 1, 0, 10, 0, 0, SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_BND, 1, 0, 10, 0, 0, SLEN_MIN));
      send_beat(srsh_pkg::KIND_RECORD, record_beat(srsh_pkg::VT_INVTRA, 1, 0, 10, 0, 0,
                                                   SLEN_MIN));
      // small reversed size with the lowest stated length
      send_beat(srsh_pkg::KIND_RECORD, record_beat(VT_GEN_FIRST, 1, 10, 3, 0, 0, SLEN_MIN));
      // read back the bins touched above
      foreach (probe_bins[i])
         send_beat(srsh_pkg::KIND_READ, read_beat(probe_bins[i]));
      drain_results();

      // random bursts with gaps between them
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if (sent < RANDOM_BEATS) begin
               if ($urandom_range(0, 99) < 65)
                  send_beat(srsh_pkg::KIND_RECORD, random_record());
               else
                  send_beat(srsh_pkg::KIND_READ, random_read());
               sent++;
            end
         end
         if (!mid_drained && sent >= RANDOM_BEATS / 2) begin
            drain_results();
            mid_drained = 1'b1;
         end
         gap = $urandom_range(0, 99);
         if (gap < 30)
            gap = 0;
         else if (gap < 95)
            gap = $urandom_range(1, 10);
         else
            gap = $urandom_range(20, 60);
         pause_sender(gap);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d record beats (%0d of skipped types)", n_records, n_skipped);
      $display("and %0d bin reads (%0d past the last bin)", n_reads, n_oob);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
